>>> hw/rtl/lie_pkg.sv
// Package for the interpolation evaluator: field widths, payload layout and
// the control struct shared by the top level and the serial multiplier.
// Depends on nothing.
`default_nettype none
package lie_pkg;
	localparam int COORD_W = 24;
	localparam int MAG_W = 25;
	localparam int VALUE_W = 32;
	localparam int IDX_W = 3;
	localparam int IN_DATA_W = 80;
	localparam int OUT_DATA_W = 32;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [MAG_W-1:0] mag_t;

	typedef struct packed {
		logic init;
		logic start;
	} mul_ctl_t;
endpackage
`default_nettype wire

>>> hw/rtl/lagrange_interpolation_eval_unit.sv
// Lagrange interpolation evaluator. A load request (tuser 0) writes one node into slot
// node_index. An evaluate request (tuser 1) returns the polynomial value at query_x in
// Q20.12, saturated, and the next request is taken only once the evaluator is back in
// idle. The time is set by the bit-serial multiplier and divider that all terms share,
// and an evaluation also waits at its end while an earlier result is still not taken.
// Nodes circulate through a ring of cells. Every slot must be written first.
// Depends on lie_pkg, lie_cell, lie_mul and lie_div.
`default_nettype none
module lagrange_interpolation_eval_unit #(
	parameter int NODES = 6
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// node_index[2:0], node_x[26:3], node_y[50:27], query_x[74:51], zero fill above.
	input  wire logic [lie_pkg::IN_DATA_W-1:0] s_tdata,
	// op[0].
	input  wire logic [0:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// value[31:0].
	output logic [lie_pkg::OUT_DATA_W-1:0] m_tdata,
	// saturated[0], bad_nodes[1].
	output logic [1:0]       m_tuser
);
	import lie_pkg::*;

	localparam int NW = COORD_W * NODES + 1;
	localparam int AW = NW + 6;
	localparam int IW = (NODES > 2) ? $clog2(NODES) : 1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_CAPT, ST_MSTART, ST_MWAIT, ST_DSTART, ST_DWAIT, ST_OUT
	} state_t;

	state_t state_q;
	coord_t cx [NODES];
	coord_t cy [NODES];
	logic [NODES-1:0] ld;
	logic rot;
	coord_t xi_q, q_q;
	logic neg_q, bad_q;
	logic [IW-1:0] i_q, j_q;
	logic signed [AW-1:0] acc_q, term;
	logic m_valid_q, sat_q, badout_q;
	logic [VALUE_W-1:0] value_q;
	mul_ctl_t mctl;
	mag_t ma, mb;
	logic signed [MAG_W-1:0] da, db;
	logic [NW-1:0] num, den, quo;
	logic mdone, ddone, dstart, acc_fits, accept;
	logic [IDX_W-1:0] in_idx;

	assign accept = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign in_idx = s_tdata[IDX_W-1:0];
	assign rot = (state_q == ST_CAPT) || (state_q == ST_MSTART) || (state_q == ST_DSTART);

	for (genvar k = 0; k < NODES; k++) begin : g_cell
		assign ld[k] = accept && (s_tuser[0] == OP_LOAD) && (32'(in_idx) == k);
		lie_cell u_cell (
			.clk(clk), .arst_n(arst_n), .ld(ld[k]),
			.ld_x(s_tdata[26:3]), .ld_y(s_tdata[50:27]), .rot(rot),
			.nb_x(cx[(k + 1) % NODES]), .nb_y(cy[(k + 1) % NODES]),
			.x(cx[k]), .y(cy[k])
		);
	end

	assign da = {q_q[COORD_W-1], q_q} - {cx[0][COORD_W-1], cx[0]};
	assign db = {xi_q[COORD_W-1], xi_q} - {cx[0][COORD_W-1], cx[0]};
	assign ma = da[MAG_W-1] ? mag_t'(-da) : mag_t'(da);
	assign mb = db[MAG_W-1] ? mag_t'(-db) : mag_t'(db);
	assign mctl.init = (state_q == ST_CAPT);
	assign mctl.start = (state_q == ST_MSTART);
	assign dstart = (state_q == ST_DSTART);

	lie_mul #(.NW(NW)) u_mul (
		.clk(clk), .arst_n(arst_n), .ctl(mctl),
		.init_mag(cy[0][COORD_W-1] ? COORD_W'(-cy[0]) : COORD_W'(cy[0])),
		.ma(ma), .mb(mb), .num(num), .den(den), .done(mdone)
	);

	lie_div #(.NW(NW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .n(num), .d(den),
		.quo(quo), .done(ddone)
	);

	assign term = neg_q ? -$signed(AW'(quo)) : $signed(AW'(quo));
	assign acc_fits = (acc_q[AW-1:VALUE_W-1] == '0) || (acc_q[AW-1:VALUE_W-1] == '1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_valid_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			q_q <= '0;
			xi_q <= '0;
			neg_q <= 1'b0;
			bad_q <= 1'b0;
			acc_q <= '0;
			value_q <= '0;
			sat_q <= 1'b0;
			badout_q <= 1'b0;
		end else begin
			if (m_valid_q && m_tready && (state_q != ST_OUT))
				m_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && (s_tuser[0] == OP_EVAL)) begin
						q_q <= s_tdata[74:51];
						i_q <= '0;
						acc_q <= '0;
						bad_q <= 1'b0;
						state_q <= ST_CAPT;
					end
				end
				ST_CAPT: begin
					xi_q <= cx[0];
					neg_q <= cy[0][COORD_W-1];
					j_q <= '0;
					state_q <= ST_MSTART;
				end
				ST_MSTART: begin
					neg_q <= neg_q ^ da[MAG_W-1] ^ db[MAG_W-1];
					if (db == '0)
						bad_q <= 1'b1;
					state_q <= ST_MWAIT;
				end
				ST_MWAIT: begin
					if (mdone) begin
						if (j_q == IW'(NODES - 2)) begin
							state_q <= ST_DSTART;
						end else begin
							j_q <= j_q + 1'b1;
							state_q <= ST_MSTART;
						end
					end
				end
				ST_DSTART: begin
					state_q <= ST_DWAIT;
				end
				ST_DWAIT: begin
					if (ddone) begin
						acc_q <= acc_q + term;
						if (i_q == IW'(NODES - 1)) begin
							state_q <= ST_OUT;
						end else begin
							i_q <= i_q + 1'b1;
							state_q <= ST_CAPT;
						end
					end
				end
				ST_OUT: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						badout_q <= bad_q;
						if (bad_q) begin
							value_q <= '0;
							sat_q <= 1'b0;
						end else if (acc_fits) begin
							value_q <= acc_q[VALUE_W-1:0];
							sat_q <= 1'b0;
						end else begin
							value_q <= acc_q[AW-1] ? {1'b1, {(VALUE_W-1){1'b0}}}
								: {1'b0, {(VALUE_W-1){1'b1}}};
							sat_q <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = value_q;
	assign m_tuser = {badout_q, sat_q};

`ifndef SYNTHESIS
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> (m_tdata == '0) && !m_tuser[0])
		else $error("bad node result is not zero");
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata == 32'h7FFFFFFF) || (m_tdata == 32'h80000000))
		else $error("saturated result is not at a rail");
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[0] |=> !s_tready)
		else $error("request taken while an evaluation runs");
`endif
endmodule
`default_nettype wire

>>> hw/rtl/lie_cell.sv
// One cell of the node ring: holds one (x, y) node pair.
// Loads from the input side or takes its neighbor's pair on a rotate.
// Depends on lie_pkg.
`default_nettype none
module lie_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           ld,
	input  wire lie_pkg::coord_t ld_x,
	input  wire lie_pkg::coord_t ld_y,
	input  wire logic           rot,
	input  wire lie_pkg::coord_t nb_x,
	input  wire lie_pkg::coord_t nb_y,
	output lie_pkg::coord_t      x,
	output lie_pkg::coord_t      y
);
	import lie_pkg::*;

	coord_t x_q, y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
		end else if (ld) begin
			x_q <= ld_x;
			y_q <= ld_y;
		end else if (rot) begin
			x_q <= nb_x;
			y_q <= nb_y;
		end
	end

	assign x = x_q;
	assign y = y_q;
endmodule
`default_nettype wire

>>> hw/rtl/lie_mul.sv
// Serial shift-add multiplier that scales the numerator and denominator
// products by one 25-bit magnitude each, one multiplier bit per cycle.
// Depends on lie_pkg.
`default_nettype none
module lie_mul #(
	parameter int NW = 145
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lie_pkg::mul_ctl_t ctl,
	input  wire logic [lie_pkg::COORD_W-1:0] init_mag,
	input  wire lie_pkg::mag_t     ma,
	input  wire lie_pkg::mag_t     mb,
	output logic [NW-1:0]          num,
	output logic [NW-1:0]          den,
	output logic                   done
);
	import lie_pkg::*;

	localparam int CW = $clog2(MAG_W + 1);

	logic [NW-1:0] num_q, den_q, pn_q, pd_q, pn_d, pd_d;
	mag_t ma_q, mb_q;
	logic [CW-1:0] cnt_q;
	logic busy_q, done_q;

	assign pn_d = {pn_q[NW-2:0], 1'b0} + (ma_q[MAG_W-1] ? num_q : '0);
	assign pd_d = {pd_q[NW-2:0], 1'b0} + (mb_q[MAG_W-1] ? den_q : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(MAG_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			num_q <= NW'(init_mag);
			den_q <= NW'(1);
		end else if (ctl.start) begin
			ma_q <= ma;
			mb_q <= mb;
			pn_q <= '0;
			pd_q <= '0;
		end else if (busy_q) begin
			pn_q <= pn_d;
			pd_q <= pd_d;
			ma_q <= {ma_q[MAG_W-2:0], 1'b0};
			mb_q <= {mb_q[MAG_W-2:0], 1'b0};
			if (cnt_q == CW'(1)) begin
				num_q <= pn_d;
				den_q <= pd_d;
			end
		end
	end

	assign num = num_q;
	assign den = den_q;
	assign done = done_q;
endmodule
`default_nettype wire

>>> hw/rtl/lie_div.sv
// Restoring shift-subtract divider, one quotient bit per cycle.
// Gives floor(n / d) for unsigned NW-bit operands. Depends on nothing.
`default_nettype none
module lie_div #(
	parameter int NW = 145
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] n,
	input  wire logic [NW-1:0] d,
	output logic [NW-1:0]      quo,
	output logic               done
);
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] n_q, d_q, r_q, q_q;
	logic [NW:0] rs, rd;
	logic ge;
	logic [CW-1:0] cnt_q;
	logic busy_q, done_q;

	assign rs = {r_q, n_q[NW-1]};
	assign rd = rs - {1'b0, d_q};
	assign ge = (rs >= {1'b0, d_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= n;
			d_q <= d;
			r_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[NW-2:0], 1'b0};
			r_q <= ge ? rd[NW-1:0] : rs[NW-1:0];
			q_q <= {q_q[NW-2:0], ge};
		end
	end

	assign quo = q_q;
	assign done = done_q;
endmodule
`default_nettype wire
